@@ sv/tgf_pkg.sv @@
// Shared types, constants and the 5x7 glyph table for the text glyph frame buffer.
package tgf_pkg;

    // Item modes
    localparam logic [2:0] MODE_CLEAR    = 3'd0;
    localparam logic [2:0] MODE_DRAW     = 3'd1;
    localparam logic [2:0] MODE_HDR_CHAR = 3'd2;
    localparam logic [2:0] MODE_HDR_BAR  = 3'd3;
    localparam logic [2:0] MODE_READ     = 3'd4;

    localparam logic [7:0] GLYPH_FIRST    = 8'd32;
    localparam logic [7:0] GLYPH_LAST     = 8'd122;
    localparam logic [7:0] GLYPH_FALLBACK = 8'd63;   // '?'
    localparam int         CELL_WIDTH     = 6;       // five glyph columns plus spacer
    localparam logic [7:0] BYTE_SET       = 8'hFF;
    localparam logic [7:0] BYTE_CLR       = 8'h00;

    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] column;
        logic [2:0] page_row;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       accepted;
    } t_out_item;

    // Finished result offered by the sequencer to the output register
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_CELL,
        ST_BAR,
        ST_RD_REQ,
        ST_RD_WAIT,
        ST_DONE
    } t_state;

    // Glyph columns, column 0 in bits [7:0]; bit 0 is the top pixel.
    function automatic logic [39:0] glyph_bits(input logic [7:0] code);
        case (code)
            8'd32:   return 40'h0000000000;
            8'd33:   return 40'h00005F0000;
            8'd34:   return 40'h0007000700;
            8'd35:   return 40'h147F147F14;
            8'd36:   return 40'h122A7F2A24;
            8'd37:   return 40'h6264081323;
            8'd38:   return 40'h5022554936;
            8'd39:   return 40'h0000030500;
            8'd40:   return 40'h0041221C00;
            8'd41:   return 40'h001C224100;
            8'd42:   return 40'h14083E0814;
            8'd43:   return 40'h08083E0808;
            8'd44:   return 40'h0000305000;
            8'd45:   return 40'h0808080808;
            8'd46:   return 40'h0000606000;
            8'd47:   return 40'h0204081020;
            8'd48:   return 40'h3E4549513E;
            8'd49:   return 40'h00407F4200;
            8'd50:   return 40'h4649516142;
            8'd51:   return 40'h314B454121;
            8'd52:   return 40'h107F121418;
            8'd53:   return 40'h3945454527;
            8'd54:   return 40'h3049494A3C;
            8'd55:   return 40'h0305097101;
            8'd56:   return 40'h3649494936;
            8'd57:   return 40'h1E29494906;
            8'd58:   return 40'h0000363600;
            8'd59:   return 40'h0000365600;
            8'd60:   return 40'h0041221408;
            8'd61:   return 40'h1414141414;
            8'd62:   return 40'h0814224100;
            8'd63:   return 40'h0609510102;
            8'd64:   return 40'h3E41794932;
            8'd65:   return 40'h7E1111117E;
            8'd66:   return 40'h364949497F;
            8'd67:   return 40'h224141413E;
            8'd68:   return 40'h1C2241417F;
            8'd69:   return 40'h414949497F;
            8'd70:   return 40'h010909097F;
            8'd71:   return 40'h7A4949413E;
            8'd72:   return 40'h7F0808087F;
            8'd73:   return 40'h00417F4100;
            8'd74:   return 40'h013F414020;
            8'd75:   return 40'h412214087F;
            8'd76:   return 40'h404040407F;
            8'd77:   return 40'h7F020C027F;
            8'd78:   return 40'h7F1008047F;
            8'd79:   return 40'h3E4141413E;
            8'd80:   return 40'h060909097F;
            8'd81:   return 40'h5E2151413E;
            8'd82:   return 40'h462919097F;
            8'd83:   return 40'h3249494926;
            8'd84:   return 40'h01017F0101;
            8'd85:   return 40'h3F4040403F;
            8'd86:   return 40'h1F2040201F;
            8'd87:   return 40'h3F4038403F;
            8'd88:   return 40'h6314081463;
            8'd89:   return 40'h0708700807;
            8'd90:   return 40'h4345495161;
            8'd91:   return 40'h0041417F00;
            8'd92:   return 40'h2010080402;
            8'd93:   return 40'h007F414100;
            8'd94:   return 40'h0402010204;
            8'd95:   return 40'h4040404040;
            8'd96:   return 40'h0004020100;
            8'd97:   return 40'h7854545420;
            8'd98:   return 40'h384444487F;
            8'd99:   return 40'h2044444438;
            8'd100:  return 40'h7F48444438;
            8'd101:  return 40'h1854545438;
            8'd102:  return 40'h0201097E08;
            8'd103:  return 40'h3E5252520C;
            8'd104:  return 40'h780404087F;
            8'd105:  return 40'h00407D4400;
            8'd106:  return 40'h003D444020;
            8'd107:  return 40'h004428107F;
            8'd108:  return 40'h00407F4100;
            8'd109:  return 40'h780418047C;
            8'd110:  return 40'h780404087C;
            8'd111:  return 40'h3844444438;
            8'd112:  return 40'h081414147C;
            8'd113:  return 40'h7C18141408;
            8'd114:  return 40'h080404087C;
            8'd115:  return 40'h2054545448;
            8'd116:  return 40'h2040443E04;
            8'd117:  return 40'h7C2040403C;
            8'd118:  return 40'h1C2040201C;
            8'd119:  return 40'h3C4030403C;
            8'd120:  return 40'h4428102844;
            8'd121:  return 40'h3C5050500C;
            8'd122:  return 40'h444C546444;
            default: return 40'h0609510102;
        endcase
    endfunction

endpackage

@@ sv/text_glyph_framebuffer_top.sv @@
// Top level of the text glyph frame buffer: sequencer, frame store and output register.
// Draw char / header char: six store writes through the single write port, then a
//   hand-over state and a return to idle.
// Read: address, registered RAM read, hand-over.
// Clear: one store byte zeroed per cycle.
// Reset (i_rst_n low, synchronous) empties the output register and starts a zeroing pass
//   over the whole store; o_in_ready stays low until it completes.
module text_glyph_framebuffer_top #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tgf_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tgf_pkg::t_out_item o_out_item
);

    tgf_pkg::t_res      w_res;
    logic               w_take;
    logic               r_out_valid;
    tgf_pkg::t_out_item r_out_item;

    // Sequencer owns the frame store; one transaction in flight at a time.
    tgf_ctrl #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_res      (w_res),
        .i_res_take (w_take)
    );

    // Output register: a finished result moves here so the sequencer can take
    // the next transaction while the consumer stalls.
    assign w_take = w_res.valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            r_out_item <= w_res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ sv/tgf_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module tgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tgf_ctrl.sv @@
// Sequencer and address unit driving the frame store, one store access per cycle.
module tgf_ctrl #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tgf_pkg::t_in_item i_in_item,
    output tgf_pkg::t_res     o_res,
    input  logic              i_res_take
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);

    tgf_pkg::t_state    r_state, n_state;
    logic [AW-1:0]      r_addr,  n_addr;
    logic [AW-1:0]      r_last,  n_last;
    logic [47:0]        r_cell,  n_cell;
    logic               r_inv,   n_inv;
    logic               r_boot,  n_boot;
    tgf_pkg::t_out_item r_res,   n_res;

    logic [AW-1:0] w_addr_inc;
    logic [AW-1:0] w_base;
    logic          w_code_ok;
    logic [7:0]    w_code;
    logic          w_draw_ok;
    logic          w_hdr_ok;
    logic          w_rd_ok;
    logic          w_we;
    logic [7:0]    w_wdata;
    logic [7:0]    w_rdata;

    // Shared incrementer: steps the store address
    assign w_addr_inc = r_addr + AW'(1);

    assign w_base    = AW'(int'(i_in_item.page_row) * COLUMNS + int'(i_in_item.column));
    assign w_code_ok = (i_in_item.char_code >= tgf_pkg::GLYPH_FIRST) &&
                       (i_in_item.char_code <= tgf_pkg::GLYPH_LAST);
    assign w_code    = w_code_ok ? i_in_item.char_code : tgf_pkg::GLYPH_FALLBACK;
    assign w_draw_ok = (int'(i_in_item.column) <= COLUMNS - tgf_pkg::CELL_WIDTH) &&
                       (int'(i_in_item.page_row) < PAGES);
    assign w_hdr_ok  = (int'(i_in_item.column) < COLUMNS - tgf_pkg::CELL_WIDTH) && w_code_ok;
    assign w_rd_ok   = (int'(i_in_item.page_row) < PAGES) &&
                       (int'(i_in_item.column) < COLUMNS);

    tgf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tgf_pkg::ST_SWEEP;
            r_addr  <= '0;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_boot  <= n_boot;
        end
        r_last <= n_last;
        r_cell <= n_cell;
        r_inv  <= n_inv;
        r_res  <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_last  = r_last;
        n_cell  = r_cell;
        n_inv   = r_inv;
        n_boot  = r_boot;
        n_res   = r_res;
        w_we    = 1'b0;
        w_wdata = tgf_pkg::BYTE_CLR;

        case (r_state)
            tgf_pkg::ST_SWEEP: begin
                w_we = 1'b1;
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_state = r_boot ? tgf_pkg::ST_IDLE : tgf_pkg::ST_DONE;
                    n_boot  = 1'b0;
                end else begin
                    n_addr = w_addr_inc;
                end
            end
            tgf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_res   = '0;
                    n_state = tgf_pkg::ST_DONE;
                    case (i_in_item.mode)
                        tgf_pkg::MODE_CLEAR: begin
                            n_addr         = '0;
                            n_res.accepted = 1'b1;
                            n_state        = tgf_pkg::ST_SWEEP;
                        end
                        tgf_pkg::MODE_DRAW: begin
                            if (w_draw_ok) begin
                                n_addr         = w_base;
                                n_last         = w_base + AW'(tgf_pkg::CELL_WIDTH - 1);
                                n_cell         = {tgf_pkg::BYTE_CLR,
                                                  tgf_pkg::glyph_bits(w_code)};
                                n_inv          = 1'b0;
                                n_res.accepted = 1'b1;
                                n_state        = tgf_pkg::ST_CELL;
                            end
                        end
                        tgf_pkg::MODE_HDR_CHAR: begin
                            if (w_hdr_ok) begin
                                n_addr         = AW'(i_in_item.column);
                                n_last         = AW'(i_in_item.column) +
                                                 AW'(tgf_pkg::CELL_WIDTH - 1);
                                n_cell         = {tgf_pkg::BYTE_CLR,
                                                  tgf_pkg::glyph_bits(w_code)};
                                n_inv          = 1'b1;
                                n_res.accepted = 1'b1;
                                n_state        = tgf_pkg::ST_CELL;
                            end
                        end
                        tgf_pkg::MODE_HDR_BAR: begin
                            n_addr         = '0;
                            n_last         = AW'(COLUMNS - 1);
                            n_res.accepted = 1'b1;
                            n_state        = tgf_pkg::ST_BAR;
                        end
                        tgf_pkg::MODE_READ: begin
                            if (w_rd_ok) begin
                                n_addr         = w_base;
                                n_res.accepted = 1'b1;
                                n_state        = tgf_pkg::ST_RD_REQ;
                            end
                        end
                        default: begin
                            n_state = tgf_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            tgf_pkg::ST_CELL: begin
                // spacer rides in the top byte, so inversion turns it into 0xFF
                w_we    = 1'b1;
                w_wdata = r_cell[7:0] ^ {8{r_inv}};
                n_cell  = r_cell >> 8;
                if (r_addr == r_last) begin
                    n_state = tgf_pkg::ST_DONE;
                end else begin
                    n_addr = w_addr_inc;
                end
            end
            tgf_pkg::ST_BAR: begin
                w_we    = 1'b1;
                w_wdata = tgf_pkg::BYTE_SET;
                if (r_addr == r_last) begin
                    n_state = tgf_pkg::ST_DONE;
                end else begin
                    n_addr = w_addr_inc;
                end
            end
            tgf_pkg::ST_RD_REQ: begin
                n_state = tgf_pkg::ST_RD_WAIT;
            end
            tgf_pkg::ST_RD_WAIT: begin
                n_res.read_byte = w_rdata;
                n_state         = tgf_pkg::ST_DONE;
            end
            tgf_pkg::ST_DONE: begin
                if (i_res_take) begin
                    n_state = tgf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tgf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == tgf_pkg::ST_IDLE);
    assign o_res      = {(r_state == tgf_pkg::ST_DONE), r_res};

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tgf_pkg::ST_IDLE) |-> !w_we)
        else $error("store written while idle");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (int'(r_addr) < DEPTH))
        else $error("store write beyond depth");

    a_read_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.item.read_byte != 8'h00)) |-> o_res.item.accepted)
        else $error("read data on a rejected transaction");

    a_bar_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_item.mode == tgf_pkg::MODE_HDR_BAR))
        |=> ((r_state == tgf_pkg::ST_BAR) && (r_addr == '0)))
        else $error("bar fill did not start at column zero");

    a_cell_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == tgf_pkg::ST_CELL) && (r_addr == r_last))
        |=> (r_state == tgf_pkg::ST_DONE))
        else $error("glyph cell overran its last column");

endmodule

@@ test/text_glyph_framebuffer_checker.sv @@
// Channel monitor with frame store predictor and result comparison for the glyph frame buffer.
module text_glyph_framebuffer_checker #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  tgf_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  tgf_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_results_due
);

    localparam int STORE_BYTES = COLUMNS * PAGES;
    localparam int REPORT_CAP  = 100;

    // 5x7 font, codes 32..122, first code at the top end; column 0 is the top byte of each glyph
    localparam logic [91*40-1:0] FONT_TABLE = {
        40'h0000000000, 40'h00005F0000, 40'h0007000700,
        40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
        40'h3649552250, 40'h0005030000, 40'h001C224100,
        40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
        40'h4261514946, 40'h2141454B31, 40'h1814127F10,
        40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000,
        40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413E,
        40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
        40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
        40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
        40'h2649494932, 40'h01017F0101, 40'h3F4040403F,
        40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
        40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204,
        40'h4040404040, 40'h0001020400, 40'h2054545478,
        40'h7F48444438, 40'h3844444420, 40'h384444487F,
        40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
        40'h7C08040478, 40'h3844444438, 40'h7C14141408,
        40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043E444020, 40'h3C4040207C, 40'h1C2040201C,
        40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44
    };

    logic [7:0]         frame_model [0:STORE_BYTES-1];
    tgf_pkg::t_out_item awaited_results [$];
    int                 result_no;

    initial begin
        o_fail_count  = 0;
        o_results_due = 0;
        result_no     = 0;
    end

    function automatic logic [7:0] font_column(input logic [7:0] code, input int col);
        return FONT_TABLE[(int'(tgf_pkg::GLYPH_LAST) - int'(code)) * 40 + (4 - col) * 8 +: 8];
    endfunction

    function automatic logic glyph_known(input logic [7:0] code);
        return code >= tgf_pkg::GLYPH_FIRST && code <= tgf_pkg::GLYPH_LAST;
    endfunction

    function automatic void write_cell(input int base, input logic [7:0] code,
                                       input logic invert, input logic [7:0] spacer);
        logic [7:0] line;
        for (int i = 0; i < 5; i++) begin
            line = font_column(code, i);
            if (base + i < STORE_BYTES)
                frame_model[base + i] = invert ? ~line : line;
        end
        if (base + 5 < STORE_BYTES)
            frame_model[base + 5] = spacer;
    endfunction

    // Applies one transaction to the model store and returns the result it should produce
    function automatic tgf_pkg::t_out_item predict_item(input tgf_pkg::t_in_item it);
        tgf_pkg::t_out_item res;
        logic [7:0]         code;
        res.read_byte = tgf_pkg::BYTE_CLR;
        res.accepted  = 1'b0;
        code          = it.char_code;
        case (it.mode)
            tgf_pkg::MODE_CLEAR: begin
                for (int i = 0; i < STORE_BYTES; i++)
                    frame_model[i] = tgf_pkg::BYTE_CLR;
                res.accepted = 1'b1;
            end
            tgf_pkg::MODE_DRAW: begin
                if (int'(it.column) <= COLUMNS - tgf_pkg::CELL_WIDTH &&
                    int'(it.page_row) < PAGES) begin
                    if (!glyph_known(code))
                        code = tgf_pkg::GLYPH_FALLBACK;
                    write_cell(int'(it.page_row) * COLUMNS + int'(it.column), code,
                               1'b0, tgf_pkg::BYTE_CLR);
                    res.accepted = 1'b1;
                end
            end
            tgf_pkg::MODE_HDR_CHAR: begin
                if (int'(it.column) < COLUMNS - tgf_pkg::CELL_WIDTH && glyph_known(code)) begin
                    write_cell(int'(it.column), code, 1'b1, tgf_pkg::BYTE_SET);
                    res.accepted = 1'b1;
                end
            end
            tgf_pkg::MODE_HDR_BAR: begin
                for (int i = 0; i < COLUMNS; i++)
                    frame_model[i] = tgf_pkg::BYTE_SET;
                res.accepted = 1'b1;
            end
            tgf_pkg::MODE_READ: begin
                if (int'(it.page_row) < PAGES && int'(it.column) < COLUMNS) begin
                    res.read_byte = frame_model[int'(it.page_row) * COLUMNS + int'(it.column)];
                    res.accepted  = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (o_fail_count < REPORT_CAP)
            $display("ERROR result %0d: %s", result_no, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        tgf_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_BYTES; i++)
                frame_model[i] = tgf_pkg::BYTE_CLR;
            awaited_results.delete();
            o_results_due <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", i_out_item));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_item.read_byte !== want.read_byte)
                        report_mismatch($sformatf("read_byte exp %h got %h",
                                                  want.read_byte, i_out_item.read_byte));
                    if (i_out_item.accepted !== want.accepted)
                        report_mismatch($sformatf("accepted exp %b got %b",
                                                  want.accepted, i_out_item.accepted));
                end
                result_no++;
            end
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(predict_item(i_in_item));
            o_results_due <= awaited_results.size();
        end
    end

endmodule

@@ test/text_glyph_framebuffer_top_tb.sv @@
// Stimulus, idling control, watchdog and verdict for the text glyph frame buffer.
module text_glyph_framebuffer_top_tb;

    localparam int COLUMNS = 128;
    localparam int PAGES   = 8;

    // Modes the block leaves undecoded
    localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

    // Longest quiet spell allowed: reset sweep or a full clear plus
    // worst sender gap and receiver stall, taken several times over.
    localparam int QUIET_LIMIT   = 6000;
    localparam int SETTLE_CYCLES = 20;
    localparam int GAP_CAP       = 40;
    localparam int PHASE_ITEMS   = 450;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    tgf_pkg::t_in_item  i_in_item   = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    tgf_pkg::t_out_item o_out_item;

    int fail_total;
    int results_due;
    int idle_pct  = 0;      // chance per cycle that the sender holds off
    int stall_pct = 0;      // chance per cycle that the receiver stalls
    int quiet_cycles = 0;
    int last_col  = 0;      // where the most recent glyph went, to aim reads at it
    int last_page = 0;

    text_glyph_framebuffer_top #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    text_glyph_framebuffer_checker #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_item    (o_out_item),
        .o_fail_count  (fail_total),
        .o_results_due (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: any cycle moving a transaction on either channel resets the count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("text_glyph_framebuffer_top: mismatch");
                $finish;
            end
        end
    end

    function automatic tgf_pkg::t_in_item mk(input logic [2:0] mode,
                                             input logic [6:0] column,
                                             input logic [2:0] page_row,
                                             input logic [7:0] code);
        tgf_pkg::t_in_item it;
        it.mode      = mode;
        it.column    = column;
        it.page_row  = page_row;
        it.char_code = code;
        return it;
    endfunction

    // Mostly glyph writes followed by reads aimed at them; clears and bar fills are rare
    // because each writes a whole pass over the store, page 0 only for a bar fill.
    function automatic tgf_pkg::t_in_item random_item();
        tgf_pkg::t_in_item it;
        int pick;
        pick         = $urandom_range(99);
        it.column    = 7'($urandom_range(127));
        it.page_row  = 3'($urandom_range(7));
        it.char_code = ($urandom_range(99) < 70)
                       ? 8'($urandom_range(tgf_pkg::GLYPH_LAST, tgf_pkg::GLYPH_FIRST))
                       : 8'($urandom_range(255));
        if (pick < 1) begin
            it.mode = tgf_pkg::MODE_CLEAR;
        end else if (pick < 3) begin
            it.mode = tgf_pkg::MODE_HDR_BAR;
        end else if (pick < 35) begin
            it.mode   = tgf_pkg::MODE_DRAW;
            last_col  = int'(it.column);
            last_page = int'(it.page_row);
        end else if (pick < 50) begin
            it.mode   = tgf_pkg::MODE_HDR_CHAR;
            last_col  = int'(it.column);
            last_page = 0;
        end else if (pick < 97) begin
            it.mode = tgf_pkg::MODE_READ;
            if ($urandom_range(99) < 60) begin
                it.column   = 7'(last_col + int'($urandom_range(5)));
                it.page_row = 3'(last_page);
            end
        end else begin
            it.mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
        end
        return it;
    endfunction

    // One input transaction: optional idle gap, then hold valid until the block takes it.
    // Valid is never dropped between back-to-back transactions.
    task automatic send(input tgf_pkg::t_in_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < GAP_CAP)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Sender stops until every predicted result has been delivered
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        idle_pct  = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            send(random_item());
            // mid-phase pause with the pipe emptied
            if (n == count / 2)
                drain();
        end
        drain();
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at full rate: field extremes, every mode, boundary columns,
        // fallback glyph for out-of-range codes, header rejections.
        send(mk(tgf_pkg::MODE_READ,     7'd0,   3'd0, 8'd0));     // fresh store reads zero
        send(mk(tgf_pkg::MODE_DRAW,     7'd0,   3'd0, 8'd65));
        send(mk(tgf_pkg::MODE_READ,     7'd2,   3'd0, 8'd0));
        send(mk(tgf_pkg::MODE_DRAW,     7'd122, 3'd7, 8'd122));   // last column that fits
        send(mk(tgf_pkg::MODE_READ,     7'd127, 3'd7, 8'd255));   // its spacer
        send(mk(tgf_pkg::MODE_DRAW,     7'd123, 3'd7, 8'd33));    // one past the edge
        send(mk(tgf_pkg::MODE_DRAW,     7'd127, 3'd7, 8'd255));
        send(mk(tgf_pkg::MODE_DRAW,     7'd10,  3'd3, 8'd31));    // below glyph range: '?'
        send(mk(tgf_pkg::MODE_DRAW,     7'd16,  3'd3, 8'd123));   // above range: '?'
        send(mk(tgf_pkg::MODE_DRAW,     7'd22,  3'd3, 8'd128));   // high-bit code: '?'
        send(mk(tgf_pkg::MODE_DRAW,     7'd28,  3'd3, 8'd32));    // space
        send(mk(tgf_pkg::MODE_READ,     7'd12,  3'd3, 8'd0));
        send(mk(tgf_pkg::MODE_HDR_CHAR, 7'd121, 3'd5, 8'd32));    // last header column
        send(mk(tgf_pkg::MODE_HDR_CHAR, 7'd122, 3'd0, 8'd65));    // rejected on column
        send(mk(tgf_pkg::MODE_HDR_CHAR, 7'd0,   3'd0, 8'd123));   // rejected on code
        send(mk(tgf_pkg::MODE_HDR_CHAR, 7'd6,   3'd0, 8'd31));
        send(mk(tgf_pkg::MODE_HDR_CHAR, 7'd0,   3'd7, 8'd122));
        send(mk(tgf_pkg::MODE_READ,     7'd0,   3'd0, 8'd0));
        send(mk(tgf_pkg::MODE_HDR_BAR,  7'd127, 3'd7, 8'd255));
        send(mk(tgf_pkg::MODE_READ,     7'd127, 3'd0, 8'd0));
        send(mk(MODE_SPARE_LO,          7'd127, 3'd7, 8'd255));
        send(mk(MODE_SPARE_MID,         7'd0,   3'd0, 8'd0));
        send(mk(MODE_SPARE_HI,          7'd127, 3'd7, 8'd255));
        send(mk(tgf_pkg::MODE_CLEAR,    7'd0,   3'd0, 8'd0));
        send(mk(tgf_pkg::MODE_READ,     7'd127, 3'd0, 8'd0));     // bar gone after clear
        drain();

        // Random part: free running, sender idling, receiver stalling, then both
        run_phase(0,  0,  PHASE_ITEMS);
        run_phase(82, 0,  PHASE_ITEMS);
        run_phase(0,  82, PHASE_ITEMS);
        run_phase(32, 32, PHASE_ITEMS);

        // Let anything stray surface before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_total == 0)
            $display("text_glyph_framebuffer_top: match");
        else
            $display("text_glyph_framebuffer_top: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/tgf_pkg.sv
sv/tgf_ram.sv
sv/tgf_ctrl.sv
sv/text_glyph_framebuffer_top.sv
test/text_glyph_framebuffer_checker.sv
test/text_glyph_framebuffer_top_tb.sv
